// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by the top-level RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked check, masked while reset is held.
`define TLQE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication checked on the next clock.
`define TLQE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tlqe_pkg.sv -----
// ----------------------------------------------------------------------------
// tlqe_pkg
// Shared types, constants and helpers of the thick line quad expander.
// ----------------------------------------------------------------------------
`default_nettype none

package tlqe_pkg;

    localparam int CoordW    = 24;
    localparam int ColorW    = 4;
    localparam int SlotW     = 3;
    localparam int NormW     = 9;   // signed normal component, |n| <= 128
    localparam int FifoDepth = 4;

    localparam logic [SlotW-1:0] SLOT_S_MINUS_A = 3'd0;
    localparam logic [SlotW-1:0] SLOT_E_MINUS   = 3'd1;
    localparam logic [SlotW-1:0] SLOT_E_PLUS_A  = 3'd2;
    localparam logic [SlotW-1:0] SLOT_S_MINUS_B = 3'd3;
    localparam logic [SlotW-1:0] SLOT_E_PLUS_B  = 3'd4;
    localparam logic [SlotW-1:0] SLOT_S_PLUS    = 3'd5;
    localparam logic [SlotW-1:0] LastSlot       = SLOT_S_PLUS;

    localparam logic signed [CoordW-1:0] CoordMax = 24'sh7FFFFF;
    localparam logic signed [CoordW-1:0] CoordMin = 24'sh800000;

    // Segment with its finished normal, as queued between front and back
    typedef struct packed {
        logic signed [CoordW-1:0] sx;
        logic signed [CoordW-1:0] sy;
        logic signed [CoordW-1:0] ex;
        logic signed [CoordW-1:0] ey;
        logic signed [NormW-1:0]  nx;
        logic signed [NormW-1:0]  ny;
        logic [ColorW-1:0]        color;
        logic                     fend;
    } t_seg;

    // Which endpoint and which sign each vertex slot takes
    function automatic logic [1:0] slot_mode(input logic [SlotW-1:0] slot);
        logic [1:0] m;  // {use_end, add}
        unique case (slot)
            SLOT_S_MINUS_A: m = 2'b00;
            SLOT_E_MINUS:   m = 2'b10;
            SLOT_E_PLUS_A:  m = 2'b11;
            SLOT_S_MINUS_B: m = 2'b00;
            SLOT_E_PLUS_B:  m = 2'b11;
            SLOT_S_PLUS:    m = 2'b01;
            default:        m = 2'b00;
        endcase
        return m;
    endfunction

    // base +/- n, clamped to the coordinate range
    function automatic logic signed [CoordW-1:0] sat_add(
        input logic signed [CoordW-1:0] base,
        input logic signed [NormW-1:0]  n,
        input logic                     add
    );
        logic signed [CoordW:0] b;
        logic signed [CoordW:0] d;
        logic signed [CoordW:0] sum;
        b   = {base[CoordW-1], base};
        d   = {{(CoordW+1-NormW){n[NormW-1]}}, n};
        sum = add ? (b + d) : (b - d);
        if (sum[CoordW] != sum[CoordW-1]) begin
            return sum[CoordW] ? CoordMin : CoordMax;
        end
        return sum[CoordW-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/thick_line_quad_expander.sv -----
// ----------------------------------------------------------------------------
// thick_line_quad_expander
// Expands a line segment into two triangles covering a one pixel wide quad.
// ----------------------------------------------------------------------------
// Each segment yields six vertices, one per pop, so the sustained rate is set
// by the one-vertex-per-cycle result port while the receiver keeps popping.
// The front pipeline takes a segment every cycle while not full (30 stages:
// capture, deltas, squares, sum, one quotient bit and one root bit per stage)
// and drains into a short queue, so bursts are absorbed until the queue fills;
// from the queue the emitter loads each segment and registers its vertices.
`default_nettype none

module thick_line_quad_expander
    import tlqe_pkg::*;
#(
    parameter int QueueDepth = FifoDepth
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     push,
    output logic                          full,
    input  wire logic signed [CoordW-1:0] i_start_x,
    input  wire logic signed [CoordW-1:0] i_start_y,
    input  wire logic signed [CoordW-1:0] i_end_x,
    input  wire logic signed [CoordW-1:0] i_end_y,
    input  wire logic [ColorW-1:0]        i_color_code,
    input  wire logic                     i_list_end,
    output logic                          empty,
    input  wire logic                     pop,
    output logic signed [CoordW-1:0]      o_vert_x,
    output logic signed [CoordW-1:0]      o_vert_y,
    output logic [ColorW-1:0]             o_vert_color,
    output logic [SlotW-1:0]              o_vert_slot,
    output logic                          o_last_vertex,
    output logic                          o_frame_end
);

`include "assert_macros.svh"

    logic w_seg_vld;
    t_seg w_seg;
    logic w_q_full;
    logic w_q_empty;
    logic w_q_pop;
    t_seg w_q_data;

    // Front: normal computation
    tlqe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_color_code (i_color_code),
        .i_list_end   (i_list_end),
        .o_seg_vld    (w_seg_vld),
        .o_seg        (w_seg),
        .i_q_full     (w_q_full)
    );

    // Segment queue
    tlqe_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_seg_vld),
        .i_data  (w_seg),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_data),
        .o_empty (w_q_empty)
    );

    // Back: vertex emission
    tlqe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .i_q_data      (w_q_data),
        .o_q_pop       (w_q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_vert_x      (o_vert_x),
        .o_vert_y      (o_vert_y),
        .o_vert_color  (o_vert_color),
        .o_vert_slot   (o_vert_slot),
        .o_last_vertex (o_last_vertex),
        .o_frame_end   (o_frame_end)
    );

    // Checks
    `TLQE_ASSERT(a_last_on_slot5, empty || (o_last_vertex == (o_vert_slot == LastSlot)), "last_vertex off slot 5")
    `TLQE_ASSERT(a_fend_only_last, empty || o_last_vertex || !o_frame_end, "frame_end before last vertex")
    `TLQE_ASSERT_NEXT(a_slot_follows, pop && !empty && !o_last_vertex, !empty && (o_vert_slot == $past(o_vert_slot) + SlotW'(1)), "vertex slot sequence broken")

endmodule

`default_nettype wire

// ----- rtl/tlqe_front.sv -----
// ----------------------------------------------------------------------------
// tlqe_front
// Segment pipeline: deltas, squares, bit-per-stage division and square root,
// then the rounded signed normal. Takes one segment per cycle while not full.
// ----------------------------------------------------------------------------
`default_nettype none

module tlqe_front
    import tlqe_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    output logic                          o_full,
    input  wire logic signed [CoordW-1:0] i_start_x,
    input  wire logic signed [CoordW-1:0] i_start_y,
    input  wire logic signed [CoordW-1:0] i_end_x,
    input  wire logic signed [CoordW-1:0] i_end_y,
    input  wire logic [ColorW-1:0]        i_color_code,
    input  wire logic                     i_list_end,
    output logic                          o_seg_vld,
    output t_seg                          o_seg,
    input  wire logic                     i_q_full
);

    localparam int MagW   = CoordW;         // |delta| < 2^24
    localparam int SqW    = 2 * MagW;
    localparam int SW     = SqW + 1;
    localparam int QW     = 17;             // quotient <= 2^16
    localparam int RW     = 9;              // root <= 256
    localparam int DivLo  = 4;              // first division stage
    localparam int SqrLo  = DivLo + QW;     // first root stage
    localparam int NSt    = SqrLo + RW;

    typedef struct packed {
        logic signed [CoordW-1:0] sx;
        logic signed [CoordW-1:0] sy;
        logic signed [CoordW-1:0] ex;
        logic signed [CoordW-1:0] ey;
        logic [ColorW-1:0]        color;
        logic                     fend;
        logic                     dy_pos;
        logic                     dx_neg;
        logic                     szero;
        logic [MagW-1:0]          adx;
        logic [MagW-1:0]          ady;
        logic [SqW-1:0]           sqx;
        logic [SqW-1:0]           sqy;
        logic [SW-1:0]            s;
        logic [SW-1:0]            remx;
        logic [SW-1:0]            remy;
        logic [QW-1:0]            qx;
        logic [QW-1:0]            qy;
        logic [RW-1:0]            rx;
        logic [RW-1:0]            ry;
    } t_pipe;

    // One restoring division step: {quotient bit, remainder}
    function automatic logic [SW:0] div_step(
        input logic [SW-1:0] rem,
        input logic [SW-1:0] s,
        input logic          first
    );
        logic [SW:0] cand;
        logic [SW:0] diff;
        cand = first ? {1'b0, rem} : {rem, 1'b0};
        diff = cand - {1'b0, s};
        if (cand >= {1'b0, s}) begin
            return {1'b1, diff[SW-1:0]};
        end
        return {1'b0, cand[SW-1:0]};
    endfunction

    // One square root step: keep the trial bit if its square fits
    function automatic logic [RW-1:0] sqrt_step(
        input logic [RW-1:0] r,
        input logic [QW-1:0] f,
        input logic [RW-1:0] bitv
    );
        logic [RW-1:0]   t;
        logic [2*RW-1:0] sq;
        t  = r | bitv;
        sq = t * t;
        return (sq <= {1'b0, f}) ? t : r;
    endfunction

    t_pipe        r_st [NSt];
    t_pipe        n_st [NSt];
    logic [NSt-1:0] r_vld;
    logic         w_en;

    // Whole pipeline holds only when the last stage cannot drain
    assign w_en   = !r_vld[NSt-1] || !i_q_full;
    assign o_full = !w_en;

    // Stage 0: capture
    always_comb begin
        n_st[0]       = r_st[0];
        n_st[0].sx    = i_start_x;
        n_st[0].sy    = i_start_y;
        n_st[0].ex    = i_end_x;
        n_st[0].ey    = i_end_y;
        n_st[0].color = i_color_code;
        n_st[0].fend  = i_list_end;
    end

    for (genvar k = 1; k < NSt; k++) begin : g_st
        t_pipe w_n;
        if (k == 1) begin : g_delta
            // Deltas and their magnitudes
            logic signed [CoordW:0] w_dx;
            logic signed [CoordW:0] w_dy;
            logic [CoordW:0]        w_ax;
            logic [CoordW:0]        w_ay;
            assign w_dx = {r_st[0].ex[CoordW-1], r_st[0].ex}
                        - {r_st[0].sx[CoordW-1], r_st[0].sx};
            assign w_dy = {r_st[0].ey[CoordW-1], r_st[0].ey}
                        - {r_st[0].sy[CoordW-1], r_st[0].sy};
            assign w_ax = w_dx[CoordW] ? -w_dx : w_dx;
            assign w_ay = w_dy[CoordW] ? -w_dy : w_dy;
            always_comb begin
                w_n        = r_st[0];
                w_n.adx    = w_ax[MagW-1:0];
                w_n.ady    = w_ay[MagW-1:0];
                w_n.dy_pos = !w_dy[CoordW] && (w_dy != '0);
                w_n.dx_neg = w_dx[CoordW];
            end
        end else if (k == 2) begin : g_sq
            // Squares; nx uses |dy|, ny uses |dx|
            always_comb begin
                w_n     = r_st[1];
                w_n.sqx = r_st[1].ady * r_st[1].ady;
                w_n.sqy = r_st[1].adx * r_st[1].adx;
            end
        end else if (k == 3) begin : g_sum
            always_comb begin
                w_n       = r_st[2];
                w_n.s     = {1'b0, r_st[2].sqx} + {1'b0, r_st[2].sqy};
                w_n.szero = (r_st[2].sqx == '0) && (r_st[2].sqy == '0);
                w_n.remx  = {1'b0, r_st[2].sqx};
                w_n.remy  = {1'b0, r_st[2].sqy};
                w_n.qx    = '0;
                w_n.qy    = '0;
                w_n.rx    = '0;
                w_n.ry    = '0;
            end
        end else if (k < SqrLo) begin : g_div
            // Quotient bit (SqrLo-1-k) of sq * 2^16 / s
            localparam int Bi = SqrLo - 1 - k;
            logic [SW:0] w_x;
            logic [SW:0] w_y;
            assign w_x = div_step(r_st[k-1].remx, r_st[k-1].s, k == DivLo);
            assign w_y = div_step(r_st[k-1].remy, r_st[k-1].s, k == DivLo);
            always_comb begin
                w_n        = r_st[k-1];
                w_n.remx   = w_x[SW-1:0];
                w_n.remy   = w_y[SW-1:0];
                w_n.qx[Bi] = w_x[SW];
                w_n.qy[Bi] = w_y[SW];
            end
        end else begin : g_sqrt
            // Root bit (NSt-1-k)
            localparam logic [RW-1:0] BitV = RW'(1) << (NSt - 1 - k);
            always_comb begin
                w_n    = r_st[k-1];
                w_n.rx = sqrt_step(r_st[k-1].rx, r_st[k-1].qx, BitV);
                w_n.ry = sqrt_step(r_st[k-1].ry, r_st[k-1].qy, BitV);
            end
        end
        assign n_st[k] = w_n;
    end

    // Pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSt-2:0], i_push};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st <= n_st;
        end
    end

    // Round half up of root/2, then sign; zero length gives zero normal
    logic [RW:0]            w_rx1;
    logic [RW:0]            w_ry1;
    logic signed [NormW-1:0] w_mx;
    logic signed [NormW-1:0] w_my;
    assign w_rx1 = {1'b0, r_st[NSt-1].rx} + (RW+1)'(1);
    assign w_ry1 = {1'b0, r_st[NSt-1].ry} + (RW+1)'(1);
    assign w_mx  = w_rx1[RW:1];
    assign w_my  = w_ry1[RW:1];

    always_comb begin
        o_seg       = '0;
        o_seg.sx    = r_st[NSt-1].sx;
        o_seg.sy    = r_st[NSt-1].sy;
        o_seg.ex    = r_st[NSt-1].ex;
        o_seg.ey    = r_st[NSt-1].ey;
        o_seg.color = r_st[NSt-1].color;
        o_seg.fend  = r_st[NSt-1].fend;
        if (!r_st[NSt-1].szero) begin
            o_seg.nx = r_st[NSt-1].dy_pos ? -w_mx : w_mx;
            o_seg.ny = r_st[NSt-1].dx_neg ? -w_my : w_my;
        end
    end

    assign o_seg_vld = r_vld[NSt-1] && !i_q_full;

endmodule

`default_nettype wire

// ----- rtl/tlqe_fifo.sv -----
// ----------------------------------------------------------------------------
// tlqe_fifo
// Short segment queue between the front pipeline and the vertex emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module tlqe_fifo
    import tlqe_pkg::*;
#(
    parameter int Depth = FifoDepth
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_seg i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_seg      o_data,
    output logic      o_empty
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    t_seg          r_mem [Depth];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_full  = (r_cnt == CW'(Depth));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == AW'(Depth - 1)) ? '0 : r_wp + AW'(1);
            end
            if (w_rd) begin
                r_rp <= (r_rp == AW'(Depth - 1)) ? '0 : r_rp + AW'(1);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tlqe_back.sv -----
// ----------------------------------------------------------------------------
// tlqe_back
// Vertex emitter: walks the six slots of the current segment, one vertex per
// transaction, through a registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tlqe_back
    import tlqe_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_q_empty,
    input  wire t_seg                i_q_data,
    output logic                     o_q_pop,
    input  wire logic                i_pop,
    output logic                     o_empty,
    output logic signed [CoordW-1:0] o_vert_x,
    output logic signed [CoordW-1:0] o_vert_y,
    output logic [ColorW-1:0]        o_vert_color,
    output logic [SlotW-1:0]         o_vert_slot,
    output logic                     o_last_vertex,
    output logic                     o_frame_end
);

    t_seg             r_cur;
    logic             r_cv;
    logic [SlotW-1:0] r_slot;
    logic             r_ov;
    logic             w_load;
    logic             w_last;
    logic [1:0]       w_mode;

    assign w_load  = r_cv && (!r_ov || i_pop);
    assign w_last  = (r_slot == LastSlot);
    assign o_q_pop = !i_q_empty && (!r_cv || (w_load && w_last));
    assign w_mode  = slot_mode(r_slot);
    assign o_empty = !r_ov;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv   <= 1'b0;
            r_slot <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
            if (o_q_pop) begin
                r_cv   <= 1'b1;
                r_slot <= '0;
            end else if (w_load) begin
                r_cv   <= !w_last;
                r_slot <= r_slot + SlotW'(1);
            end
        end
    end

    // Segment and result payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_data;
        end
        if (w_load) begin
            o_vert_x      <= sat_add(w_mode[1] ? r_cur.ex : r_cur.sx, r_cur.nx, w_mode[0]);
            o_vert_y      <= sat_add(w_mode[1] ? r_cur.ey : r_cur.sy, r_cur.ny, w_mode[0]);
            o_vert_color  <= r_cur.color;
            o_vert_slot   <= r_slot;
            o_last_vertex <= w_last;
            o_frame_end   <= w_last && r_cur.fend;
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/thick_line_quad_expander_test.sv -----
// ----------------------------------------------------------------------------
// thick_line_quad_expander_test
// Self-checking bench for the segment to quad vertex expander: a directed
// table followed by random segments, every vertex checked against a predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module thick_line_quad_expander_test;
    import tlqe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic [ColorW-1:0]        color;
        logic [SlotW-1:0]         slot;
        logic                     last;
        logic                     fend;
    } t_vert;

    typedef struct packed {
        logic signed [CoordW-1:0] sx;
        logic signed [CoordW-1:0] sy;
        logic signed [CoordW-1:0] ex;
        logic signed [CoordW-1:0] ey;
        logic [ColorW-1:0]        color;
        logic                     lend;
        logic                     has_x;   // x0 holds a typed-in expected x of slot 0
        logic signed [CoordW-1:0] x0;
    } t_row;

    localparam int RandItems = 310;
    localparam int CycleLimit = 200000;

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    logic signed [CoordW-1:0] i_start_x, i_start_y, i_end_x, i_end_y;
    logic [ColorW-1:0] i_color_code;
    logic i_list_end;
    logic empty;
    logic pop;
    logic signed [CoordW-1:0] o_vert_x, o_vert_y;
    logic [ColorW-1:0] o_vert_color;
    logic [SlotW-1:0] o_vert_slot;
    logic o_last_vertex, o_frame_end;

    t_vert expected_verts[$];
    int    mismatches = 0;
    int    cycles = 0;
    bit    stim_done = 0;

    thick_line_quad_expander u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_start_x(i_start_x), .i_start_y(i_start_y),
        .i_end_x(i_end_x), .i_end_y(i_end_y),
        .i_color_code(i_color_code), .i_list_end(i_list_end),
        .empty(empty), .pop(pop),
        .o_vert_x(o_vert_x), .o_vert_y(o_vert_y), .o_vert_color(o_vert_color),
        .o_vert_slot(o_vert_slot), .o_last_vertex(o_last_vertex),
        .o_frame_end(o_frame_end)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Integer square root, floor
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // round(128 * mag / sqrt(s)), ties away from zero
    function automatic longint half_norm(longint unsigned mag, longint unsigned s);
        longint unsigned f;
        f = ((mag * mag) << 16) / s;
        return longint'((int_sqrt(f) + 1) / 2);
    endfunction

    function automatic logic signed [CoordW-1:0] clamp_coord(longint v);
        if (v > 64'sd8388607) return CoordMax;
        if (v < -64'sd8388608) return CoordMin;
        return v[CoordW-1:0];
    endfunction

    // Queue the six vertices a segment should produce
    task automatic predict_quad(t_row r);
        longint sx, sy, ex, ey, dx, dy, nx, ny, px, py;
        longint unsigned adx, ady, s;
        t_vert v;
        sx = r.sx; sy = r.sy; ex = r.ex; ey = r.ey;
        dx = ex - sx; dy = ey - sy;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        s = adx * adx + ady * ady;
        nx = 0; ny = 0;
        if (s != 0) begin
            nx = half_norm(ady, s);
            ny = half_norm(adx, s);
            if (dy > 0) nx = -nx;
            if (dx < 0) ny = -ny;
        end
        for (int k = 0; k < 6; k++) begin
            case (k)
                0, 3: begin px = sx - nx; py = sy - ny; end
                1: begin px = ex - nx; py = ey - ny; end
                2, 4: begin px = ex + nx; py = ey + ny; end
                default: begin px = sx + nx; py = sy + ny; end
            endcase
            v.x = clamp_coord(px);
            v.y = clamp_coord(py);
            v.color = r.color;
            v.slot = k[SlotW-1:0];
            v.last = (k == 5);
            v.fend = (k == 5) ? r.lend : 1'b0;
            expected_verts.push_back(v);
        end
    endtask

    function automatic logic signed [CoordW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return CoordW'(CoordMax - $urandom_range(0, 300));
            1: return CoordW'(CoordMin + $urandom_range(0, 300));
            2: return CoordW'($urandom_range(0, 2000) - 1000);
            default: return CoordW'($urandom());
        endcase
    endfunction

    // Send one segment transaction, with a random lead-in gap
    task automatic send_segment(t_row r);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start_x <= r.sx; i_start_y <= r.sy;
        i_end_x <= r.ex; i_end_y <= r.ey;
        i_color_code <= r.color; i_list_end <= r.lend;
        push <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_quad(r);
        @(negedge i_clk);
    endtask

    // Stimulus
    initial begin
        t_row table_rows[$];
        t_row r;
        logic signed [CoordW-1:0] base;
        push = 0; i_start_x = 0; i_start_y = 0; i_end_x = 0; i_end_y = 0;
        i_color_code = 0; i_list_end = 0;
        i_rst_n = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // zero length, axis aligned, diagonals, oblique slopes, saturation at both bounds
        table_rows = '{
            '{0, 0, 0, 0, 4'h0, 0, 1, 0},
            '{CoordMax, CoordMax, CoordMax, CoordMax, 4'hF, 1, 1, CoordMax},
            '{CoordMin, CoordMin, CoordMin, CoordMin, 4'h5, 0, 1, CoordMin},
            '{0, 0, 256, 0, 4'h1, 0, 1, 0},
            '{0, 0, -256, 0, 4'h2, 1, 1, 0},
            '{0, 0, 0, 256, 4'h3, 0, 1, 128},
            '{0, 0, 0, -256, 4'h4, 0, 1, -128},
            '{0, 0, 256, 256, 4'h6, 0, 0, 0},
            '{0, 0, -256, -256, 4'h7, 1, 0, 0},
            '{0, 0, 1, 1, 4'h8, 0, 0, 0},
            '{0, 0, 1, 2, 4'h9, 0, 0, 0},
            '{CoordMax, 0, CoordMax, 1000, 4'hA, 0, 0, 0},
            '{CoordMin, 0, CoordMin, -1000, 4'hB, 0, 0, 0},
            '{0, CoordMax, 1000, CoordMax, 4'hC, 0, 0, 0},
            '{0, CoordMin, -1000, CoordMin, 4'hD, 1, 0, 0},
            '{CoordMin, CoordMin, CoordMax, CoordMax, 4'hE, 0, 0, 0},
            '{CoordMax, CoordMin, CoordMin, CoordMax, 4'h5, 1, 0, 0},
            '{24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555, 4'hA, 0, 0, 0},
            '{24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA, 4'h5, 1, 0, 0},
            '{0, 0, 3, -7, 4'h0, 0, 0, 0}
        };
        foreach (table_rows[i]) begin
            send_segment(table_rows[i]);
            if (table_rows[i].has_x &&
                expected_verts[expected_verts.size() - 6].x !== table_rows[i].x0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row %0d: predicted x %0d, typed %0d", i,
                             expected_verts[expected_verts.size() - 6].x,
                             table_rows[i].x0);
            end
        end
        push <= 1'b0;

        // hold off until every queued vertex has drained
        while (expected_verts.size() != 0) @(negedge i_clk);

        for (int n = 0; n < RandItems; n++) begin
            base = rand_coord();
            r.sx = base; r.sy = rand_coord();
            // mostly short segments near the start, some anywhere
            if ($urandom_range(0, 3) != 0) begin
                r.ex = CoordW'(r.sx + ($urandom_range(0, 4000) - 2000));
                r.ey = CoordW'(r.sy + ($urandom_range(0, 4000) - 2000));
            end else begin
                r.ex = rand_coord();
                r.ey = rand_coord();
            end
            if ($urandom_range(0, 15) == 0) begin r.ex = r.sx; r.ey = r.sy; end
            r.color = ColorW'($urandom());
            r.lend = 1'($urandom());
            r.has_x = 0; r.x0 = 0;
            send_segment(r);
        end
        push <= 1'b0;
        stim_done = 1;
    end

    // Receiver: random stalls, sample and check at the rising edge
    initial begin
        int gap;
        t_vert want;
        pop = 0;
        gap = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (expected_verts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("vertex with nothing expected");
                end else begin
                    want = expected_verts.pop_front();
                    if (o_vert_x !== want.x || o_vert_y !== want.y ||
                        o_vert_color !== want.color || o_vert_slot !== want.slot ||
                        o_last_vertex !== want.last || o_frame_end !== want.fend) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch exp x=%0d y=%0d c=%0h s=%0d l=%0b f=%0b",
                                      " got %0d %0d %0h %0d %0b %0b"},
                                     want.x, want.y, want.color, want.slot, want.last,
                                     want.fend, o_vert_x, o_vert_y,
                                     o_vert_color, o_vert_slot, o_last_vertex,
                                     o_frame_end);
                    end
                end
                gap = $urandom_range(0, 5);
            end
            @(negedge i_clk);
            if (gap > 0) begin
                gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog and end of run
    initial begin
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CycleLimit) begin
                $display("[thick_line_quad_expander] ERROR");
                $finish;
            end
            if (stim_done && expected_verts.size() == 0) begin
                repeat (60) @(posedge i_clk);
                if (mismatches == 0 && expected_verts.size() == 0) begin
                    $display("[thick_line_quad_expander] OK");
                end else begin
                    $display("[thick_line_quad_expander] ERROR");
                end
                $finish;
            end
        end
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/tlqe_pkg.sv
rtl/tlqe_front.sv
rtl/tlqe_fifo.sv
rtl/tlqe_back.sv
rtl/thick_line_quad_expander.sv
tb/sv/thick_line_quad_expander_test.sv
